// ===== hw/rtl/iasmd_pkg.sv =====
// Package for the integer add/sub/mul/div unit.
// Holds the operation codes and the sequencer state type; no dependencies.
package iasmd_pkg;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_REM = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_ABS_A,
    ST_ABS_B,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/iasmd_addsub.sv =====
// Shared adder/subtractor of the integer add/sub/mul/div unit.
// Used by the arithmetic steps of the sequencer; no package dependency.
module iasmd_addsub #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] op_a,
  input  logic [DATA_WIDTH-1:0] op_b,
  input  logic                  sub,
  output logic [DATA_WIDTH-1:0] sum,
  output logic                  carry
);

  logic [DATA_WIDTH:0] full;

  // For a subtraction, carry set means op_a >= op_b (no borrow).
  assign full  = {1'b0, op_a} + {1'b0, op_b ^ {DATA_WIDTH{sub}}} + {{DATA_WIDTH{1'b0}}, sub};
  assign sum   = full[DATA_WIDTH-1:0];
  assign carry = full[DATA_WIDTH];

endmodule

// ===== hw/rtl/integer_add_sub_mul_div_unit.sv =====
// Integer add/subtract/multiply/divide/remainder unit, one transaction at a time. A transaction
// is accepted when start is high and busy is low; busy then stays high until the result has
// been shown. The result appears on out_result for exactly one cycle with out_valid high and
// the receiver cannot stall it. Add and subtract go through the add/sub step, multiply through
// the shift-and-add loop, divide and remainder through the dividend and divisor magnitude
// steps, the divide loop and the sign fix step; division by zero and unused codes go straight
// to the result. All arithmetic goes through one shared adder that handles one multiplier or
// quotient bit per cycle. The next transaction can start after the strobe cycle.
// Depends on iasmd_pkg and iasmd_addsub.
module integer_add_sub_mul_div_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_kind,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  iasmd_pkg::state_t state_r, state_nxt;
  logic [2:0]            kind_r, kind_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;

  logic [DATA_WIDTH-1:0] alu_a, alu_b, alu_sum;
  logic                  alu_sub, alu_carry;
  logic                  fix_neg;

  iasmd_addsub #(.DATA_WIDTH(DATA_WIDTH)) u_addsub (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iasmd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    cnt_r   <= cnt_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign fix_neg = (kind_r == iasmd_pkg::KIND_DIV) ? neg_q_r : neg_r_r;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      iasmd_pkg::ST_ADDSUB: begin
        alu_a   = a_r;
        alu_b   = b_r;
        alu_sub = (kind_r == iasmd_pkg::KIND_SUB);
      end
      iasmd_pkg::ST_MUL: begin
        alu_a = acc_r;
        alu_b = b_r[0] ? a_r : '0;
      end
      iasmd_pkg::ST_ABS_A: begin
        alu_b   = a_r;
        alu_sub = 1'b1;
      end
      iasmd_pkg::ST_ABS_B: begin
        alu_b   = b_r;
        alu_sub = 1'b1;
      end
      iasmd_pkg::ST_DIV: begin
        // Partial remainder stays below the divisor magnitude, so its top bit is zero.
        alu_a   = {acc_r[DATA_WIDTH-2:0], a_r[DATA_WIDTH-1]};
        alu_b   = b_r;
        alu_sub = 1'b1;
      end
      iasmd_pkg::ST_FIX: begin
        alu_b   = (kind_r == iasmd_pkg::KIND_DIV) ? a_r : acc_r;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    unique case (state_r)
      iasmd_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          a_nxt    = in_operand_a;
          b_nxt    = in_operand_b;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          unique case (in_kind)
            iasmd_pkg::KIND_ADD, iasmd_pkg::KIND_SUB: begin
              state_nxt = iasmd_pkg::ST_ADDSUB;
            end
            iasmd_pkg::KIND_MUL: begin
              state_nxt = iasmd_pkg::ST_MUL;
            end
            iasmd_pkg::KIND_DIV, iasmd_pkg::KIND_REM: begin
              if (in_operand_b == '0) begin
                // Division by zero: all-ones quotient, remainder equals the dividend.
                res_nxt   = (in_kind == iasmd_pkg::KIND_DIV) ? '1 : in_operand_a;
                state_nxt = iasmd_pkg::ST_DONE;
              end else begin
                state_nxt = iasmd_pkg::ST_ABS_A;
              end
            end
            default: begin
              res_nxt   = '0;
              state_nxt = iasmd_pkg::ST_DONE;
            end
          endcase
        end
      end
      iasmd_pkg::ST_ADDSUB: begin
        res_nxt   = alu_sum;
        state_nxt = iasmd_pkg::ST_DONE;
      end
      iasmd_pkg::ST_MUL: begin
        acc_nxt = alu_sum;
        a_nxt   = {a_r[DATA_WIDTH-2:0], 1'b0};
        b_nxt   = {1'b0, b_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          res_nxt   = alu_sum;
          state_nxt = iasmd_pkg::ST_DONE;
        end
      end
      iasmd_pkg::ST_ABS_A: begin
        neg_q_nxt = a_r[DATA_WIDTH-1];
        neg_r_nxt = a_r[DATA_WIDTH-1];
        if (a_r[DATA_WIDTH-1]) begin
          a_nxt = alu_sum;
        end
        state_nxt = iasmd_pkg::ST_ABS_B;
      end
      iasmd_pkg::ST_ABS_B: begin
        neg_q_nxt = neg_q_r ^ b_r[DATA_WIDTH-1];
        if (b_r[DATA_WIDTH-1]) begin
          b_nxt = alu_sum;
        end
        state_nxt = iasmd_pkg::ST_DIV;
      end
      iasmd_pkg::ST_DIV: begin
        // Quotient bits shift into the dividend register as its bits are consumed.
        acc_nxt = alu_carry ? alu_sum : alu_a;
        a_nxt   = {a_r[DATA_WIDTH-2:0], alu_carry};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = iasmd_pkg::ST_FIX;
        end
      end
      iasmd_pkg::ST_FIX: begin
        res_nxt   = fix_neg ? alu_sum : alu_b;
        state_nxt = iasmd_pkg::ST_DONE;
      end
      iasmd_pkg::ST_DONE: begin
        state_nxt = iasmd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = iasmd_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != iasmd_pkg::ST_IDLE);
  assign out_valid  = (state_r == iasmd_pkg::ST_DONE);
  assign out_result = $signed(res_r);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the unit busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("unit stayed busy after delivering its result");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iasmd_pkg::ST_DIV) |-> (b_r != '0))
    else $error("division loop running with a zero divisor");
`endif

endmodule
